@@ rtl/core/assert_macros.svh @@
// Assertion helpers shared by the RTL. Each checks on the rising edge of clk
// and is off while rst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Check that a condition holds on every clock edge.
`define ASSERT_ALWAYS(lbl, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
    else $error("assertion failed: condition does not hold");

// Check that an antecedent implies a consequent in the same cycle.
`define ASSERT_IMPLY(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed: implication does not hold");

`else

`define ASSERT_ALWAYS(lbl, cond)
`define ASSERT_IMPLY(lbl, ante, cons)

`endif

`endif

@@ rtl/core/slcfr_pkg.sv @@
package slcfr_pkg;

  // Frame format
  localparam logic [7:0] SYNC_FIRST    = 8'hFF;
  localparam logic [7:0] SYNC_SECOND   = 8'h55;
  localparam logic [7:0] MAX_PAYLOAD   = 8'd15;
  localparam int         PAYLOAD_DEPTH = 15;

  // Parser phases
  localparam logic [2:0] PH_HUNT_FF = 3'd0;
  localparam logic [2:0] PH_WAIT_55 = 3'd1;
  localparam logic [2:0] PH_LENGTH  = 3'd2;
  localparam logic [2:0] PH_PAYLOAD = 3'd3;
  localparam logic [2:0] PH_CHECK   = 3'd4;

  // Result kinds
  localparam logic [2:0] K_PAYLOAD = 3'd0;
  localparam logic [2:0] K_EMPTY   = 3'd1;
  localparam logic [2:0] K_BADSUM  = 3'd2;
  localparam logic [2:0] K_BADSYNC = 3'd3;
  localparam logic [2:0] K_TOOLONG = 3'd4;
  localparam logic [2:0] K_LINEERR = 3'd5;

  // Commands from the parser to the emitter
  localparam logic [1:0] OP_STORE  = 2'd0;
  localparam logic [1:0] OP_SINGLE = 2'd1;
  localparam logic [1:0] OP_FRAME  = 2'd2;

  // Command queue
  localparam int QDEPTH = 4;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  typedef struct packed {
    logic [1:0] op;
    logic [2:0] kind;
    logic [3:0] len;
    logic [3:0] idx;
    logic [7:0] data;
  } cmd_t;

endpackage

@@ rtl/core/slcfr_front.sv @@
module slcfr_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [7:0]        in_rx_byte,
  input  logic              in_line_error,
  input  logic              q_full,
  output logic              push,
  output slcfr_pkg::cmd_t   cmd
);
  import slcfr_pkg::*;

  logic [2:0] phase_r, phase_nxt;
  logic [7:0] sum_r, sum_nxt;
  logic [3:0] rem_r, rem_nxt;
  logic [3:0] len_r, len_nxt;
  logic [3:0] wpos_r, wpos_nxt;
  logic       accept;
  logic [7:0] expect_sum;

  assign in_ready   = !q_full;
  assign accept     = in_valid && !q_full;
  assign expect_sum = 8'd0 - sum_r;

  always_comb begin
    phase_nxt = phase_r;
    sum_nxt   = sum_r;
    rem_nxt   = rem_r;
    len_nxt   = len_r;
    wpos_nxt  = wpos_r;
    push      = 1'b0;
    cmd       = '0;
    if (accept) begin
      if (in_line_error) begin
        push      = 1'b1;
        cmd.op    = OP_SINGLE;
        cmd.kind  = K_LINEERR;
        phase_nxt = PH_HUNT_FF;
        sum_nxt   = '0;
        rem_nxt   = '0;
        len_nxt   = '0;
        wpos_nxt  = '0;
      end else begin
        case (phase_r)
          PH_WAIT_55: begin
            if (in_rx_byte == SYNC_SECOND) begin
              phase_nxt = PH_LENGTH;
            end else if (in_rx_byte != SYNC_FIRST) begin
              push      = 1'b1;
              cmd.op    = OP_SINGLE;
              cmd.kind  = K_BADSYNC;
              phase_nxt = PH_HUNT_FF;
              sum_nxt   = '0;
              rem_nxt   = '0;
              len_nxt   = '0;
              wpos_nxt  = '0;
            end
          end
          PH_LENGTH: begin
            if (in_rx_byte > MAX_PAYLOAD) begin
              push      = 1'b1;
              cmd.op    = OP_SINGLE;
              cmd.kind  = K_TOOLONG;
              phase_nxt = PH_HUNT_FF;
              sum_nxt   = '0;
              rem_nxt   = '0;
              len_nxt   = '0;
              wpos_nxt  = '0;
            end else begin
              sum_nxt   = in_rx_byte;
              len_nxt   = in_rx_byte[3:0];
              rem_nxt   = in_rx_byte[3:0];
              wpos_nxt  = '0;
              phase_nxt = (in_rx_byte == 8'd0) ? PH_CHECK : PH_PAYLOAD;
            end
          end
          PH_PAYLOAD: begin
            // Hand each payload byte to the emitter for storage
            push     = 1'b1;
            cmd.op   = OP_STORE;
            cmd.idx  = wpos_r;
            cmd.data = in_rx_byte;
            sum_nxt  = sum_r + in_rx_byte;
            wpos_nxt = wpos_r + 4'd1;
            rem_nxt  = rem_r - 4'd1;
            if (rem_r == 4'd1) begin
              phase_nxt = PH_CHECK;
            end
          end
          PH_CHECK: begin
            push = 1'b1;
            if (in_rx_byte != expect_sum) begin
              cmd.op   = OP_SINGLE;
              cmd.kind = K_BADSUM;
              cmd.len  = len_r;
            end else if (len_r == 4'd0) begin
              cmd.op   = OP_SINGLE;
              cmd.kind = K_EMPTY;
            end else begin
              cmd.op   = OP_FRAME;
              cmd.kind = K_PAYLOAD;
              cmd.len  = len_r;
            end
            phase_nxt = PH_HUNT_FF;
            sum_nxt   = '0;
            rem_nxt   = '0;
            len_nxt   = '0;
            wpos_nxt  = '0;
          end
          default: begin
            phase_nxt = (in_rx_byte == SYNC_FIRST) ? PH_WAIT_55 : PH_HUNT_FF;
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_HUNT_FF;
      sum_r   <= '0;
      rem_r   <= '0;
      len_r   <= '0;
      wpos_r  <= '0;
    end else begin
      phase_r <= phase_nxt;
      sum_r   <= sum_nxt;
      rem_r   <= rem_nxt;
      len_r   <= len_nxt;
      wpos_r  <= wpos_nxt;
    end
  end

endmodule

@@ rtl/core/slcfr_fifo.sv @@
module slcfr_fifo (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  slcfr_pkg::cmd_t   push_cmd,
  output logic              full,
  output logic              pop_valid,
  input  logic              pop,
  output slcfr_pkg::cmd_t   pop_cmd
);
  import slcfr_pkg::*;

  cmd_t              entry_r [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0] cnt_r, cnt_nxt;
  logic              do_push;
  logic              do_pop;

  assign full      = (cnt_r == QCNT_W'(QDEPTH));
  assign pop_valid = (cnt_r != '0);
  assign pop_cmd   = entry_r[rd_ptr_r];
  assign do_push   = push && !full;
  assign do_pop    = pop && pop_valid;

  always_comb begin
    wr_ptr_nxt = do_push ? wr_ptr_r + QPTR_W'(1) : wr_ptr_r;
    rd_ptr_nxt = do_pop  ? rd_ptr_r + QPTR_W'(1) : rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + QCNT_W'(1);
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - QCNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      entry_r[wr_ptr_r] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

endmodule

@@ rtl/core/slcfr_back.sv @@
module slcfr_back (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cmd_valid,
  output logic              cmd_ready,
  input  slcfr_pkg::cmd_t   cmd,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [2:0]        out_kind,
  output logic [7:0]        out_data_byte,
  output logic [3:0]        out_byte_index,
  output logic [3:0]        out_frame_length,
  output logic              out_last
);
  import slcfr_pkg::*;

  localparam logic [1:0] BK_IDLE = 2'd0;
  localparam logic [1:0] BK_READ = 2'd1;
  localparam logic [1:0] BK_SHOW = 2'd2;

  logic [7:0] mem [PAYLOAD_DEPTH];
  logic [7:0] mem_q_r;

  logic [1:0] bstate_r, bstate_nxt;
  logic [3:0] ridx_r, ridx_nxt;
  logic [3:0] rlen_r, rlen_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic [2:0] out_kind_r, out_kind_nxt;
  logic [7:0] out_data_r, out_data_nxt;
  logic [3:0] out_idx_r, out_idx_nxt;
  logic [3:0] out_len_r, out_len_nxt;
  logic       out_last_r, out_last_nxt;
  logic       out_free;

  assign out_free  = !out_valid_r || out_ready;
  assign cmd_ready = (bstate_r == BK_IDLE) && cmd_valid &&
                     ((cmd.op != OP_SINGLE) || out_free);

  assign out_valid        = out_valid_r;
  assign out_kind         = out_kind_r;
  assign out_data_byte    = out_data_r;
  assign out_byte_index   = out_idx_r;
  assign out_frame_length = out_len_r;
  assign out_last         = out_last_r;

  always_comb begin
    bstate_nxt    = bstate_r;
    ridx_nxt      = ridx_r;
    rlen_nxt      = rlen_r;
    out_valid_nxt = out_valid_r;
    out_kind_nxt  = out_kind_r;
    out_data_nxt  = out_data_r;
    out_idx_nxt   = out_idx_r;
    out_len_nxt   = out_len_r;
    out_last_nxt  = out_last_r;
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end
    case (bstate_r)
      BK_IDLE: begin
        if (cmd_ready) begin
          case (cmd.op)
            OP_SINGLE: begin
              out_valid_nxt = 1'b1;
              out_kind_nxt  = cmd.kind;
              out_data_nxt  = '0;
              out_idx_nxt   = '0;
              out_len_nxt   = cmd.len;
              out_last_nxt  = 1'b1;
            end
            OP_FRAME: begin
              rlen_nxt   = cmd.len;
              ridx_nxt   = '0;
              bstate_nxt = BK_READ;
            end
            default: begin
              // store commands only write the payload memory
            end
          endcase
        end
      end
      BK_READ: begin
        bstate_nxt = BK_SHOW;
      end
      BK_SHOW: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_kind_nxt  = K_PAYLOAD;
          out_data_nxt  = mem_q_r;
          out_idx_nxt   = ridx_r;
          out_len_nxt   = rlen_r;
          out_last_nxt  = (ridx_r == rlen_r - 4'd1);
          if (ridx_r == rlen_r - 4'd1) begin
            bstate_nxt = BK_IDLE;
          end else begin
            ridx_nxt   = ridx_r + 4'd1;
            bstate_nxt = BK_READ;
          end
        end
      end
      default: begin
        bstate_nxt = BK_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd_ready && (cmd.op == OP_STORE)) begin
      mem[cmd.idx] <= cmd.data;
    end
    if (bstate_r == BK_READ) begin
      mem_q_r <= mem[ridx_r];
    end
  end

  always_ff @(posedge clk) begin
    out_kind_r <= out_kind_nxt;
    out_data_r <= out_data_nxt;
    out_idx_r  <= out_idx_nxt;
    out_len_r  <= out_len_nxt;
    out_last_r <= out_last_nxt;
    ridx_r     <= ridx_nxt;
    rlen_r     <= rlen_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bstate_r    <= BK_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      bstate_r    <= bstate_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

@@ rtl/core/sync_length_checksum_frame_receiver.sv @@
// Frame receiver for a byte stream: hunts for the sync pair FF 55, reads a
// length (0 to 15), the payload and a checksum byte that negates the sum
// of length and payload modulo 256.
// Input channel: in_rx_byte / in_line_error with in_valid / in_ready. A byte
// is taken every cycle while the four-entry command queue has room; a full
// queue drops in_ready until the result side drains.
// Result channel: out_* fields with out_valid / out_ready. A good frame
// comes out as its payload bytes in order, out_last on the final one; a
// zero-length frame, a sync, length, checksum or line fault gives one result.
// A single result passes through the command queue and the emitter's output
// registers. A good frame's payload bytes come out one at a time: each takes a
// registered read of the payload memory in the emitter (BK_READ) and then the
// output registers (BK_SHOW).
// A stalled out_ready holds the current result; the parser keeps taking
// bytes until the queue fills.
// Reset (rst_n low, synchronous) empties the queue, drops out_valid and puts
// the parser back to hunting for the first sync byte.
module sync_length_checksum_frame_receiver (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_rx_byte,
  input  logic       in_line_error,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [2:0] out_kind,
  output logic [7:0] out_data_byte,
  output logic [3:0] out_byte_index,
  output logic [3:0] out_frame_length,
  output logic       out_last
);
  import slcfr_pkg::*;

  `include "assert_macros.svh"

  cmd_t push_cmd;
  cmd_t pop_cmd;
  logic push;
  logic q_full;
  logic pop_valid;
  logic pop;

  slcfr_front u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_rx_byte    (in_rx_byte),
    .in_line_error (in_line_error),
    .q_full        (q_full),
    .push          (push),
    .cmd           (push_cmd)
  );

  slcfr_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_cmd  (push_cmd),
    .full      (q_full),
    .pop_valid (pop_valid),
    .pop       (pop),
    .pop_cmd   (pop_cmd)
  );

  slcfr_back u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd_valid        (pop_valid),
    .cmd_ready        (pop),
    .cmd              (pop_cmd),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_kind         (out_kind),
    .out_data_byte    (out_data_byte),
    .out_byte_index   (out_byte_index),
    .out_frame_length (out_frame_length),
    .out_last         (out_last)
  );

  `ASSERT_IMPLY(a_single_is_last, out_valid && (out_kind != K_PAYLOAD), out_last)
  `ASSERT_IMPLY(a_single_no_data, out_valid && (out_kind != K_PAYLOAD), out_data_byte == 8'd0)
  `ASSERT_IMPLY(a_idx_in_frame, out_valid && (out_kind == K_PAYLOAD), out_byte_index < out_frame_length)
  `ASSERT_IMPLY(a_last_at_end, out_valid && (out_kind == K_PAYLOAD), out_last == (out_byte_index == out_frame_length - 4'd1))
  `ASSERT_ALWAYS(a_queue_push_room, !(push && q_full))

endmodule

@@ test/sync_length_checksum_frame_receiver_checker.sv @@
module sync_length_checksum_frame_receiver_checker
  import slcfr_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  input  logic       in_ready,
  input  logic [7:0] in_rx_byte,
  input  logic       in_line_error,
  input  logic       out_valid,
  input  logic       out_ready,
  input  logic [2:0] out_kind,
  input  logic [7:0] out_data_byte,
  input  logic [3:0] out_byte_index,
  input  logic [3:0] out_frame_length,
  input  logic       out_last,
  output int         fail_count,
  output int         pending
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [2:0] kind;
    logic [7:0] data;
    logic [3:0] idx;
    logic [3:0] len;
    logic       last;
  } frame_result_t;

  frame_result_t expected_results[$];

  // Parser state mirrored from the block
  logic [2:0] hunt_phase;
  logic [7:0] frame_sum;
  logic [3:0] bytes_left;
  logic [3:0] frame_len;
  logic [3:0] write_pos;
  logic [7:0] payload_mem [PAYLOAD_DEPTH];

  task automatic restart_hunt();
    hunt_phase = PH_HUNT_FF;
    frame_sum  = '0;
    bytes_left = '0;
    frame_len  = '0;
    write_pos  = '0;
  endtask

  task automatic predict_byte(input logic [7:0] b, input logic line_err);
    frame_result_t r;
    logic [7:0] want_sum;
    r = '0;
    r.last = 1'b1;
    if (line_err) begin
      restart_hunt();
      r.kind = K_LINEERR;
      expected_results.push_back(r);
      return;
    end
    case (hunt_phase)
      PH_WAIT_55: begin
        if (b == SYNC_SECOND) begin
          hunt_phase = PH_LENGTH;
        end else if (b != SYNC_FIRST) begin
          restart_hunt();
          r.kind = K_BADSYNC;
          expected_results.push_back(r);
        end
      end
      PH_LENGTH: begin
        if (b > MAX_PAYLOAD) begin
          restart_hunt();
          r.kind = K_TOOLONG;
          expected_results.push_back(r);
        end else begin
          frame_sum  = b;
          frame_len  = b[3:0];
          bytes_left = b[3:0];
          write_pos  = '0;
          hunt_phase = (b == 8'd0) ? PH_CHECK : PH_PAYLOAD;
        end
      end
      PH_PAYLOAD: begin
        frame_sum = frame_sum + b;
        if (write_pos < PAYLOAD_DEPTH) payload_mem[write_pos] = b;
        write_pos = write_pos + 4'd1;
        if (bytes_left != 0) bytes_left = bytes_left - 4'd1;
        if (bytes_left == 0) hunt_phase = PH_CHECK;
      end
      PH_CHECK: begin
        want_sum = 8'h00 - frame_sum;
        if (b != want_sum) begin
          r.kind = K_BADSUM;
          r.len  = frame_len;
          expected_results.push_back(r);
        end else if (frame_len == 0) begin
          r.kind = K_EMPTY;
          expected_results.push_back(r);
        end else begin
          // replay the stored payload, last flag on the final byte
          for (int i = 0; i < frame_len; i++) begin
            r.kind = K_PAYLOAD;
            r.data = payload_mem[i];
            r.idx  = 4'(i);
            r.len  = frame_len;
            r.last = (i + 1 == frame_len);
            expected_results.push_back(r);
          end
        end
        restart_hunt();
      end
      default: begin
        hunt_phase = (b == SYNC_FIRST) ? PH_WAIT_55 : PH_HUNT_FF;
      end
    endcase
  endtask

  task automatic check_field(input string field, input int want, input int got);
    if (want != got) begin
      $display("%0t: out_%s mismatch, expected %0h, actual %0h", $time, field, want, got);
      fail_count++;
    end
  endtask

  initial begin
    fail_count = 0;
    pending = 0;
  end

  always @(posedge clk) begin
    frame_result_t exp_r;
    if (!rst_n) begin
      restart_hunt();
      expected_results.delete();
    end else begin
      if (in_valid && in_ready) predict_byte(in_rx_byte, in_line_error);
      if (out_valid && out_ready) begin
        if (expected_results.size() == 0) begin
          $display("%0t: unexpected transfer, expected none, actual kind %0d data %0h idx %0d len %0d last %0b",
                   $time, out_kind, out_data_byte, out_byte_index, out_frame_length, out_last);
          fail_count++;
        end else begin
          exp_r = expected_results.pop_front();
          check_field("kind", exp_r.kind, out_kind);
          check_field("data_byte", exp_r.data, out_data_byte);
          check_field("byte_index", exp_r.idx, out_byte_index);
          check_field("frame_length", exp_r.len, out_frame_length);
          check_field("last", exp_r.last, out_last);
        end
      end
    end
    pending = expected_results.size();
  end

endmodule

@@ test/sync_length_checksum_frame_receiver_test.sv @@
module sync_length_checksum_frame_receiver_test;
  timeunit 1ns;
  timeprecision 1ps;
  import slcfr_pkg::*;

  localparam int CYCLE_LIMIT  = 200000;
  localparam int BYTE_TARGET  = 420;
  localparam int HOLD_START   = 400;
  localparam int HOLD_CYCLES  = 300;

  logic       clk = 1'b0;
  logic       rst_n;
  logic       in_valid;
  logic       in_ready;
  logic [7:0] in_rx_byte;
  logic       in_line_error;
  logic       out_valid;
  logic       out_ready;
  logic [2:0] out_kind;
  logic [7:0] out_data_byte;
  logic [3:0] out_byte_index;
  logic [3:0] out_frame_length;
  logic       out_last;

  int fail_count;
  int pending;
  int burst_left = 0;
  int bytes_sent = 0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  sync_length_checksum_frame_receiver uut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_rx_byte       (in_rx_byte),
    .in_line_error    (in_line_error),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_kind         (out_kind),
    .out_data_byte    (out_data_byte),
    .out_byte_index   (out_byte_index),
    .out_frame_length (out_frame_length),
    .out_last         (out_last)
  );

  sync_length_checksum_frame_receiver_checker result_check (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_rx_byte       (in_rx_byte),
    .in_line_error    (in_line_error),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_kind         (out_kind),
    .out_data_byte    (out_data_byte),
    .out_byte_index   (out_byte_index),
    .out_frame_length (out_frame_length),
    .out_last         (out_last),
    .fail_count       (fail_count),
    .pending          (pending)
  );

  // Called at a falling edge; returns at the falling edge after the transfer.
  task automatic send_byte(input logic [7:0] b, input logic line_err);
    int gap;
    if (burst_left == 0) begin
      gap = $urandom_range(1, 6);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 80) : $urandom_range(1, 12);
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    burst_left--;
    in_valid      <= 1'b1;
    in_rx_byte    <= b;
    in_line_error <= line_err;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
    bytes_sent++;
  endtask

  task automatic send_frame(input int len, input bit bad_sum, input bit extra_ff);
    logic [7:0] sum;
    logic [7:0] p;
    sum = 8'(len);
    send_byte(SYNC_FIRST, 1'b0);
    if (extra_ff) send_byte(SYNC_FIRST, 1'b0);
    send_byte(SYNC_SECOND, 1'b0);
    send_byte(8'(len), 1'b0);
    for (int i = 0; i < len; i++) begin
      p = 8'($urandom_range(0, 255));
      sum = sum + p;
      send_byte(p, 1'b0);
    end
    // corrupt the checksum by a nonzero xor
    send_byte((8'h00 - sum) ^ (bad_sum ? 8'($urandom_range(1, 255)) : 8'h00), 1'b0);
  endtask

  initial begin
    int pick;
    int len;
    logic [7:0] b;
    rst_n         = 1'b0;
    in_valid      = 1'b0;
    in_rx_byte    = '0;
    in_line_error = 1'b0;
    repeat (10) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // line fault while hunting
    send_byte(8'hFF, 1'b1);
    // one-byte good frame
    send_byte(SYNC_FIRST, 1'b0);
    send_byte(SYNC_SECOND, 1'b0);
    send_byte(8'h01, 1'b0);
    send_byte(8'hAA, 1'b0);
    send_byte(8'h55, 1'b0);
    // empty frame after a repeated first sync byte
    send_byte(SYNC_FIRST, 1'b0);
    send_byte(SYNC_FIRST, 1'b0);
    send_byte(SYNC_SECOND, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'h00, 1'b0);
    // bad second sync byte
    send_byte(SYNC_FIRST, 1'b0);
    send_byte(8'h12, 1'b0);
    // length one over the limit
    send_byte(SYNC_FIRST, 1'b0);
    send_byte(SYNC_SECOND, 1'b0);
    send_byte(MAX_PAYLOAD + 8'd1, 1'b0);
    // empty frame with a wrong checksum
    send_byte(SYNC_FIRST, 1'b0);
    send_byte(SYNC_SECOND, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'h01, 1'b0);
    // line fault in the middle of the payload
    send_byte(SYNC_FIRST, 1'b0);
    send_byte(SYNC_SECOND, 1'b0);
    send_byte(8'h02, 1'b0);
    send_byte(8'h11, 1'b0);
    send_byte(8'h00, 1'b1);

    // start the random part with the longest frame
    send_frame(15, 1'b0, 1'b0);
    while (bytes_sent < BYTE_TARGET) begin
      pick = $urandom_range(0, 99);
      if (pick < 70) begin
        send_frame($urandom_range(0, 15), $urandom_range(0, 6) == 0, $urandom_range(0, 3) == 0);
      end else if (pick < 80) begin
        repeat ($urandom_range(1, 4)) send_byte(8'($urandom_range(0, 255)), 1'b0);
      end else if (pick < 87) begin
        // abort a partial frame with a line fault
        len = $urandom_range(1, 15);
        send_byte(SYNC_FIRST, 1'b0);
        send_byte(SYNC_SECOND, 1'b0);
        send_byte(8'(len), 1'b0);
        repeat ($urandom_range(0, len)) send_byte(8'($urandom_range(0, 255)), 1'b0);
        send_byte(8'($urandom_range(0, 255)), 1'b1);
      end else if (pick < 93) begin
        send_byte(SYNC_FIRST, 1'b0);
        do b = 8'($urandom_range(0, 254)); while (b == SYNC_SECOND);
        send_byte(b, 1'b0);
      end else begin
        send_byte(SYNC_FIRST, 1'b0);
        send_byte(SYNC_SECOND, 1'b0);
        send_byte(8'($urandom_range(16, 255)), 1'b0);
      end
    end
    in_valid <= 1'b0;

    while (pending != 0) @(negedge clk);
    repeat (40) @(negedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("sync_length_checksum_frame_receiver_test: clean");
    end else begin
      $display("sync_length_checksum_frame_receiver_test: errors");
    end
    $finish;
  end

  // Result side: stall pattern changes every window; one long hold-off fills the block.
  initial begin
    int rx_cycle;
    int mode;
    rx_cycle  = 0;
    mode      = 0;
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      rx_cycle++;
      if (rx_cycle == HOLD_START) begin
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        rx_cycle += HOLD_CYCLES;
      end
      if (rx_cycle % 64 == 0) mode = $urandom_range(0, 3);
      case (mode)
        0: out_ready <= 1'b1;
        1: out_ready <= ($urandom_range(0, 3) != 0);
        2: out_ready <= ($urandom_range(0, 3) == 0);
        default: out_ready <= rx_cycle[0];
      endcase
    end
  end

  initial begin
    int cycle_count;
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("sync_length_checksum_frame_receiver_test: errors");
    $finish;
  end

endmodule
